// File: src/qlsf_pkg.sv
// ----------------------------------------------------------------------------
// qlsf_pkg
// Shared types, widths and the solver microcode for the quadratic fit block.
// ----------------------------------------------------------------------------
package qlsf_pkg;

  localparam int X_W            = 10;
  localparam int Y_W            = 9;
  localparam int COEF_W         = 48;
  localparam int USED_W         = 11;
  localparam int FRAC_BITS      = 24;
  localparam int MAX_POINTS_DEF = 1024;
  localparam int QUEUE_DEPTH    = 4;

  localparam int X2_W  = 2 * X_W;
  localparam int X3_W  = 3 * X_W;
  localparam int X4_W  = 4 * X_W;
  localparam int XY_W  = X_W + Y_W;
  localparam int X2Y_W = 2 * X_W + Y_W;

  // One classified point with its powers, as it travels through the queue.
  typedef struct packed {
    logic [X_W-1:0]   x;
    logic [Y_W-1:0]   y;
    logic [X2_W-1:0]  x2;
    logic [XY_W-1:0]  xy;
    logic [X3_W-1:0]  x3;
    logic [X4_W-1:0]  x4;
    logic [X2Y_W-1:0] x2y;
    logic             keep;
    logic             last;
  } qlsf_item_t;

  typedef struct packed {
    logic signed [COEF_W-1:0] coef_const;
    logic signed [COEF_W-1:0] coef_linear;
    logic signed [COEF_W-1:0] coef_square;
    logic                     fit_valid;
    logic [USED_W-1:0]        points_used;
  } qlsf_fit_t;

  typedef struct packed {
    logic start;
    logic neg;
  } qlsf_div_req_t;

  typedef struct packed {
    logic                     done;
    logic signed [COEF_W-1:0] coef;
  } qlsf_div_rsp_t;

  // Operand sources for the serial multiply-accumulate unit.
  typedef enum logic [3:0] {
    SRC_S0, SRC_S1, SRC_S2, SRC_S3, SRC_S4,
    SRC_T0, SRC_T1, SRC_T2,
    SRC_A00, SRC_A01, SRC_A02, SRC_A11, SRC_A12, SRC_A22,
    SRC_DET
  } qlsf_src_t;

  typedef enum logic [3:0] {
    DST_NONE,
    DST_A00, DST_A01, DST_A02, DST_A11, DST_A12, DST_A22,
    DST_DET,
    DST_N0, DST_N1, DST_N2
  } qlsf_dst_t;

  typedef struct packed {
    qlsf_src_t a_sel;
    qlsf_src_t b_sel;
    logic      sub;
    logic      first;
    qlsf_dst_t dst;
  } qlsf_uop_t;

  localparam int UOP_COUNT = 24;
  localparam int UOP_IDX_W = $clog2(UOP_COUNT);
  localparam logic [UOP_IDX_W-1:0] UOP_DET_LAST = UOP_IDX_W'(14);
  localparam logic [UOP_IDX_W-1:0] UOP_FINAL    = UOP_IDX_W'(UOP_COUNT - 1);

  function automatic qlsf_uop_t mk_uop(input qlsf_src_t a, input qlsf_src_t b,
                                       input logic sub, input logic first,
                                       input qlsf_dst_t dst);
    qlsf_uop_t u;
    u.a_sel = a;
    u.b_sel = b;
    u.sub   = sub;
    u.first = first;
    u.dst   = dst;
    return u;
  endfunction

  // Cofactors of the normal matrix, its determinant, then the three
  // numerators. The B operand is always an unsigned power sum.
  function automatic qlsf_uop_t qlsf_uop(input logic [UOP_IDX_W-1:0] idx);
    qlsf_uop_t u;
    unique case (idx)
      5'd0:    u = mk_uop(SRC_S4,  SRC_S2, 1'b0, 1'b1, DST_NONE);
      5'd1:    u = mk_uop(SRC_S3,  SRC_S3, 1'b1, 1'b0, DST_A00);
      5'd2:    u = mk_uop(SRC_S3,  SRC_S2, 1'b0, 1'b1, DST_NONE);
      5'd3:    u = mk_uop(SRC_S4,  SRC_S1, 1'b1, 1'b0, DST_A01);
      5'd4:    u = mk_uop(SRC_S3,  SRC_S1, 1'b0, 1'b1, DST_NONE);
      5'd5:    u = mk_uop(SRC_S2,  SRC_S2, 1'b1, 1'b0, DST_A02);
      5'd6:    u = mk_uop(SRC_S4,  SRC_S0, 1'b0, 1'b1, DST_NONE);
      5'd7:    u = mk_uop(SRC_S2,  SRC_S2, 1'b1, 1'b0, DST_A11);
      5'd8:    u = mk_uop(SRC_S2,  SRC_S1, 1'b0, 1'b1, DST_NONE);
      5'd9:    u = mk_uop(SRC_S3,  SRC_S0, 1'b1, 1'b0, DST_A12);
      5'd10:   u = mk_uop(SRC_S2,  SRC_S0, 1'b0, 1'b1, DST_NONE);
      5'd11:   u = mk_uop(SRC_S1,  SRC_S1, 1'b1, 1'b0, DST_A22);
      5'd12:   u = mk_uop(SRC_A00, SRC_S0, 1'b0, 1'b1, DST_NONE);
      5'd13:   u = mk_uop(SRC_A01, SRC_S1, 1'b0, 1'b0, DST_NONE);
      5'd14:   u = mk_uop(SRC_A02, SRC_S2, 1'b0, 1'b0, DST_DET);
      5'd15:   u = mk_uop(SRC_A00, SRC_T0, 1'b0, 1'b1, DST_NONE);
      5'd16:   u = mk_uop(SRC_A01, SRC_T1, 1'b0, 1'b0, DST_NONE);
      5'd17:   u = mk_uop(SRC_A02, SRC_T2, 1'b0, 1'b0, DST_N0);
      5'd18:   u = mk_uop(SRC_A01, SRC_T0, 1'b0, 1'b1, DST_NONE);
      5'd19:   u = mk_uop(SRC_A11, SRC_T1, 1'b0, 1'b0, DST_NONE);
      5'd20:   u = mk_uop(SRC_A12, SRC_T2, 1'b0, 1'b0, DST_N1);
      5'd21:   u = mk_uop(SRC_A02, SRC_T0, 1'b0, 1'b1, DST_NONE);
      5'd22:   u = mk_uop(SRC_A12, SRC_T1, 1'b0, 1'b0, DST_NONE);
      5'd23:   u = mk_uop(SRC_A22, SRC_T2, 1'b0, 1'b0, DST_N2);
      default: u = mk_uop(SRC_S0,  SRC_S0, 1'b0, 1'b1, DST_NONE);
    endcase
    return u;
  endfunction

endpackage

// File: src/qlsf_point_if.sv
// ----------------------------------------------------------------------------
// qlsf_point_if
// Valid/ready channel carrying one input point.
// ----------------------------------------------------------------------------
interface qlsf_point_if;
  import qlsf_pkg::*;

  logic           valid;
  logic           ready;
  logic [X_W-1:0] point_x;
  logic [Y_W-1:0] point_y;
  logic           last_point;

  modport source(output valid, point_x, point_y, last_point, input ready);
  modport sink(input valid, point_x, point_y, last_point, output ready);
endinterface

// File: src/qlsf_fit_if.sv
// ----------------------------------------------------------------------------
// qlsf_fit_if
// Valid/ready channel carrying one fit result.
// ----------------------------------------------------------------------------
interface qlsf_fit_if;
  import qlsf_pkg::*;

  logic                     valid;
  logic                     ready;
  logic signed [COEF_W-1:0] coef_const;
  logic signed [COEF_W-1:0] coef_linear;
  logic signed [COEF_W-1:0] coef_square;
  logic                     fit_valid;
  logic [USED_W-1:0]        points_used;

  modport source(output valid, coef_const, coef_linear, coef_square, fit_valid,
                 points_used, input ready);
  modport sink(input valid, coef_const, coef_linear, coef_square, fit_valid,
               points_used, output ready);
endinterface

// File: src/quadratic_least_squares_fit.sv
// ----------------------------------------------------------------------------
// quadratic_least_squares_fit
// Degree-2 least-squares fit over a stream of points, Q23.24 coefficients.
// ----------------------------------------------------------------------------
//  port     direction  payload
//  points   in         point_x, point_y, last_point
//  fits     out        coef_const, coef_linear, coef_square, fit_valid,
//                      points_used
//
// Ordinary points are taken one per cycle unless the path to the queue stalls;
// the back end adds one queued point per cycle while it accumulates. A point
// marked last starts a solve of 24 serial multiply-accumulate steps, each
// shifting through the significant bits of its sum operand (at most
// 4*10+clog2(MAX_POINTS+1) bits), and then three serial divisions; a zero
// determinant ends the solve early, with no divisions. Reset is synchronous and
// empties the sums. Points wait in a four-deep queue during a solve, and a
// finished result waits in the output register without stopping accumulation.
// ----------------------------------------------------------------------------
module quadratic_least_squares_fit #(
  parameter int MAX_POINTS = qlsf_pkg::MAX_POINTS_DEF
) (
  input logic         clk,
  input logic         rst,
  qlsf_point_if.sink  points,
  qlsf_fit_if.source  fits
);
  import qlsf_pkg::*;

  logic       fr_valid;
  logic       fr_ready;
  qlsf_item_t fr_item;
  logic       q_valid;
  logic       q_ready;
  qlsf_item_t q_item;
  qlsf_fit_t  res;

  qlsf_front #(
    .MAX_POINTS(MAX_POINTS)
  ) u_front (
    .clk(clk),
    .rst(rst),
    .in_valid(points.valid),
    .in_ready(points.ready),
    .in_x(points.point_x),
    .in_y(points.point_y),
    .in_last(points.last_point),
    .out_valid(fr_valid),
    .out_ready(fr_ready),
    .out_item(fr_item)
  );

  qlsf_queue u_queue (
    .clk(clk),
    .rst(rst),
    .in_valid(fr_valid),
    .in_ready(fr_ready),
    .in_item(fr_item),
    .out_valid(q_valid),
    .out_ready(q_ready),
    .out_item(q_item)
  );

  qlsf_back #(
    .MAX_POINTS(MAX_POINTS)
  ) u_back (
    .clk(clk),
    .rst(rst),
    .item_valid(q_valid),
    .item_ready(q_ready),
    .item(q_item),
    .res_valid(fits.valid),
    .res_ready(fits.ready),
    .res(res)
  );

  assign fits.coef_const  = res.coef_const;
  assign fits.coef_linear = res.coef_linear;
  assign fits.coef_square = res.coef_square;
  assign fits.fit_valid   = res.fit_valid;
  assign fits.points_used = res.points_used;

endmodule

// File: src/qlsf_front.sv
// ----------------------------------------------------------------------------
// qlsf_front
// Accepts points, marks those beyond the point limit, and forms the powers.
// ----------------------------------------------------------------------------
module qlsf_front #(
  parameter int MAX_POINTS = qlsf_pkg::MAX_POINTS_DEF
) (
  input  logic                      clk,
  input  logic                      rst,
  input  logic                      in_valid,
  output logic                      in_ready,
  input  logic [qlsf_pkg::X_W-1:0]  in_x,
  input  logic [qlsf_pkg::Y_W-1:0]  in_y,
  input  logic                      in_last,
  output logic                      out_valid,
  input  logic                      out_ready,
  output qlsf_pkg::qlsf_item_t      out_item
);
  import qlsf_pkg::*;

  localparam int CW = $clog2(MAX_POINTS + 1);

  logic [CW-1:0]   cnt;
  logic            s1_valid;
  logic [X_W-1:0]  s1_x;
  logic [Y_W-1:0]  s1_y;
  logic [X2_W-1:0] s1_x2;
  logic [XY_W-1:0] s1_xy;
  logic            s1_keep;
  logic            s1_last;
  logic            adv2;
  logic            accept;
  logic            keep;

  assign adv2     = !out_valid || out_ready;
  assign in_ready = !s1_valid || adv2;
  assign accept   = in_valid && in_ready;
  assign keep     = cnt < CW'(MAX_POINTS);

  always_ff @(posedge clk) begin
    if (rst) begin
      cnt       <= '0;
      s1_valid  <= 1'b0;
      out_valid <= 1'b0;
    end else begin
      if (accept) begin
        if (in_last) begin
          cnt <= '0;
        end else if (keep) begin
          cnt <= cnt + 1'b1;
        end
      end
      if (in_ready) begin
        s1_valid <= in_valid;
      end
      if (adv2) begin
        out_valid <= s1_valid;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (accept) begin
      s1_x    <= in_x;
      s1_y    <= in_y;
      s1_x2   <= X2_W'(in_x) * X2_W'(in_x);
      s1_xy   <= XY_W'(in_x) * XY_W'(in_y);
      s1_keep <= keep;
      s1_last <= in_last;
    end
    if (adv2 && s1_valid) begin
      out_item.x    <= s1_x;
      out_item.y    <= s1_y;
      out_item.x2   <= s1_x2;
      out_item.xy   <= s1_xy;
      out_item.x3   <= X3_W'(s1_x2) * X3_W'(s1_x);
      out_item.x4   <= X4_W'(s1_x2) * X4_W'(s1_x2);
      out_item.x2y  <= X2Y_W'(s1_x2) * X2Y_W'(s1_y);
      out_item.keep <= s1_keep;
      out_item.last <= s1_last;
    end
  end

endmodule

// File: src/qlsf_queue.sv
// ----------------------------------------------------------------------------
// qlsf_queue
// Short FIFO between the front and the back.
// ----------------------------------------------------------------------------
module qlsf_queue (
  input  logic                 clk,
  input  logic                 rst,
  input  logic                 in_valid,
  output logic                 in_ready,
  input  qlsf_pkg::qlsf_item_t in_item,
  output logic                 out_valid,
  input  logic                 out_ready,
  output qlsf_pkg::qlsf_item_t out_item
);
  import qlsf_pkg::*;

  localparam int PTR_W = $clog2(QUEUE_DEPTH);

  qlsf_item_t       mem [QUEUE_DEPTH];
  logic [PTR_W-1:0] wr_ptr;
  logic [PTR_W-1:0] rd_ptr;
  logic [PTR_W:0]   fill;
  logic             push;
  logic             pop;

  assign in_ready  = fill != (PTR_W + 1)'(QUEUE_DEPTH);
  assign out_valid = fill != '0;
  assign push      = in_valid && in_ready;
  assign pop       = out_valid && out_ready;
  assign out_item  = mem[rd_ptr];

  always_ff @(posedge clk) begin
    if (rst) begin
      wr_ptr <= '0;
      rd_ptr <= '0;
      fill   <= '0;
    end else begin
      if (push) begin
        wr_ptr <= wr_ptr + 1'b1;
      end
      if (pop) begin
        rd_ptr <= rd_ptr + 1'b1;
      end
      if (push && !pop) begin
        fill <= fill + 1'b1;
      end else if (pop && !push) begin
        fill <= fill - 1'b1;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (push) begin
      mem[wr_ptr] <= in_item;
    end
  end

endmodule

// File: src/qlsf_div.sv
// ----------------------------------------------------------------------------
// qlsf_div
// Bit-serial rounding divider producing one saturated Q23.24 coefficient.
// ----------------------------------------------------------------------------
module qlsf_div #(
  parameter int NW = 127
) (
  input  logic                   clk,
  input  logic                   rst,
  input  qlsf_pkg::qlsf_div_req_t req,
  input  logic signed [NW-1:0]   num,
  input  logic [NW-1:0]          den,
  output qlsf_pkg::qlsf_div_rsp_t rsp
);
  import qlsf_pkg::*;

  localparam int DIVW = NW + FRAC_BITS + 1;
  localparam int CNTW = $clog2(DIVW + 1);
  localparam int QW   = COEF_W + 1;
  localparam logic [QW-1:0] LIM_POS = {2'b00, {(COEF_W - 1){1'b1}}};
  localparam logic [QW-1:0] LIM_NEG = {2'b01, {(COEF_W - 1){1'b0}}};

  logic            busy;
  logic            fin;
  logic [CNTW-1:0] cnt;
  logic [DIVW-1:0] nsh;
  logic [NW:0]     d;
  logic [NW:0]     r;
  logic [QW-1:0]   q;
  logic            ovf;
  logic            neg;
  logic [NW-1:0]   mag;
  logic [NW+1:0]   r_sh;
  logic            ge;
  logic [QW-1:0]   lim;
  logic [QW-1:0]   qsat;

  assign mag  = num[NW-1] ? NW'(-num) : NW'(num);
  assign r_sh = {r, nsh[DIVW-1]};
  assign ge   = r_sh >= {1'b0, d};

  // Quotient is floor((2*|num|*2^24 + den) / (2*den)), which rounds half away.
  always_ff @(posedge clk) begin
    if (rst) begin
      busy <= 1'b0;
      fin  <= 1'b0;
    end else begin
      fin <= !req.start && busy && cnt == CNTW'(1);
      if (req.start) begin
        busy <= 1'b1;
        cnt  <= CNTW'(DIVW);
        nsh  <= (DIVW'(mag) << (FRAC_BITS + 1)) + DIVW'(den);
        d    <= {den, 1'b0};
        r    <= '0;
        q    <= '0;
        ovf  <= 1'b0;
        neg  <= num[NW-1] ^ req.neg;
      end else if (busy) begin
        r   <= ge ? (NW + 1)'(r_sh - {1'b0, d}) : r_sh[NW:0];
        nsh <= nsh << 1;
        q   <= {q[QW-2:0], ge};
        ovf <= ovf | q[QW-1];
        cnt <= cnt - 1'b1;
        if (cnt == CNTW'(1)) begin
          busy <= 1'b0;
        end
      end
    end
  end

  assign lim      = neg ? LIM_NEG : LIM_POS;
  assign qsat     = (ovf || q > lim) ? lim : q;
  assign rsp.done = fin;
  assign rsp.coef = neg ? -qsat[COEF_W-1:0] : qsat[COEF_W-1:0];

endmodule

// File: src/qlsf_back.sv
// ----------------------------------------------------------------------------
// qlsf_back
// Accumulates the power sums and, on the last point, solves the normal
// equations with a serial multiply-accumulate unit and a serial divider.
// ----------------------------------------------------------------------------
module qlsf_back #(
  parameter int MAX_POINTS = qlsf_pkg::MAX_POINTS_DEF
) (
  input  logic                 clk,
  input  logic                 rst,
  input  logic                 item_valid,
  output logic                 item_ready,
  input  qlsf_pkg::qlsf_item_t item,
  output logic                 res_valid,
  input  logic                 res_ready,
  output qlsf_pkg::qlsf_fit_t  res
);
  import qlsf_pkg::*;

  localparam int CW    = $clog2(MAX_POINTS + 1);
  localparam int S1W   = X_W + CW;
  localparam int S2W   = 2 * X_W + CW;
  localparam int S3W   = 3 * X_W + CW;
  localparam int S4W   = 4 * X_W + CW;
  localparam int T0W   = Y_W + CW;
  localparam int T1W   = X_W + Y_W + CW;
  localparam int T2W   = 2 * X_W + Y_W + CW;
  localparam int BW    = S4W;
  localparam int AW    = S2W + S4W + 2;
  localparam int ACC_W = AW + T2W + 3;

  typedef enum logic [5:0] {
    ST_ACCUM = 6'b000001,
    ST_LOAD  = 6'b000010,
    ST_RUN   = 6'b000100,
    ST_DIV   = 6'b001000,
    ST_DWAIT = 6'b010000,
    ST_DONE  = 6'b100000
  } state_t;

  state_t state;

  logic [CW-1:0]  cnt;
  logic [S1W-1:0] sx;
  logic [S2W-1:0] sx2;
  logic [S3W-1:0] sx3;
  logic [S4W-1:0] sx4;
  logic [T0W-1:0] sy;
  logic [T1W-1:0] sxy;
  logic [T2W-1:0] sx2y;

  logic signed [AW-1:0]    a00, a01, a02, a11, a12, a22;
  logic signed [ACC_W-1:0] det, n0, n1, n2;
  logic signed [ACC_W-1:0] acc;
  logic signed [ACC_W-1:0] mul_a;
  logic [BW-1:0]           mul_b;
  logic [UOP_IDX_W-1:0]    uidx;
  logic [1:0]              div_idx;

  logic signed [COEF_W-1:0] c0, c1, c2;
  logic                     fv;

  qlsf_uop_t               u;
  logic signed [ACC_W-1:0] a_opnd;
  logic [BW-1:0]           b_opnd;
  logic signed [ACC_W-1:0] div_num;
  logic [ACC_W-1:0]        det_abs;
  qlsf_div_req_t           div_req;
  qlsf_div_rsp_t           div_rsp;

  assign u          = qlsf_uop(uidx);
  assign item_ready = state == ST_ACCUM;

  always_comb begin
    unique case (u.a_sel)
      SRC_S0:  a_opnd = ACC_W'(cnt);
      SRC_S1:  a_opnd = ACC_W'(sx);
      SRC_S2:  a_opnd = ACC_W'(sx2);
      SRC_S3:  a_opnd = ACC_W'(sx3);
      SRC_S4:  a_opnd = ACC_W'(sx4);
      SRC_A00: a_opnd = ACC_W'(a00);
      SRC_A01: a_opnd = ACC_W'(a01);
      SRC_A02: a_opnd = ACC_W'(a02);
      SRC_A11: a_opnd = ACC_W'(a11);
      SRC_A12: a_opnd = ACC_W'(a12);
      SRC_A22: a_opnd = ACC_W'(a22);
      default: a_opnd = '0;
    endcase
  end

  always_comb begin
    unique case (u.b_sel)
      SRC_S0:  b_opnd = BW'(cnt);
      SRC_S1:  b_opnd = BW'(sx);
      SRC_S2:  b_opnd = BW'(sx2);
      SRC_S3:  b_opnd = BW'(sx3);
      SRC_S4:  b_opnd = BW'(sx4);
      SRC_T0:  b_opnd = BW'(sy);
      SRC_T1:  b_opnd = BW'(sxy);
      SRC_T2:  b_opnd = BW'(sx2y);
      default: b_opnd = '0;
    endcase
  end

  always_comb begin
    unique case (div_idx)
      2'd0:    div_num = n0;
      2'd1:    div_num = n1;
      default: div_num = n2;
    endcase
  end

  assign det_abs       = det[ACC_W-1] ? ACC_W'(-det) : ACC_W'(det);
  assign div_req.start = state == ST_DIV;
  assign div_req.neg   = det[ACC_W-1];

  qlsf_div #(
    .NW(ACC_W)
  ) u_div (
    .clk(clk),
    .rst(rst),
    .req(div_req),
    .num(div_num),
    .den(det_abs),
    .rsp(div_rsp)
  );

  always_ff @(posedge clk) begin
    if (rst) begin
      res_valid <= 1'b0;
    end else if (state == ST_DONE && (!res_valid || res_ready)) begin
      res_valid <= 1'b1;
    end else if (res_valid && res_ready) begin
      res_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state     <= ST_ACCUM;
      cnt       <= '0;
      sx        <= '0;
      sx2       <= '0;
      sx3       <= '0;
      sx4       <= '0;
      sy        <= '0;
      sxy       <= '0;
      sx2y      <= '0;
    end else begin
      unique case (state)
        ST_ACCUM: begin
          if (item_valid) begin
            if (item.keep) begin
              cnt  <= cnt + 1'b1;
              sx   <= sx + S1W'(item.x);
              sx2  <= sx2 + S2W'(item.x2);
              sx3  <= sx3 + S3W'(item.x3);
              sx4  <= sx4 + S4W'(item.x4);
              sy   <= sy + T0W'(item.y);
              sxy  <= sxy + T1W'(item.xy);
              sx2y <= sx2y + T2W'(item.x2y);
            end
            if (item.last) begin
              uidx  <= '0;
              state <= ST_LOAD;
            end
          end
        end
        ST_LOAD: begin
          mul_a <= a_opnd;
          mul_b <= b_opnd;
          if (u.first) begin
            acc <= '0;
          end
          state <= ST_RUN;
        end
        ST_RUN: begin
          if (mul_b == '0) begin
            unique case (u.dst)
              DST_A00: a00 <= AW'(acc);
              DST_A01: a01 <= AW'(acc);
              DST_A02: a02 <= AW'(acc);
              DST_A11: a11 <= AW'(acc);
              DST_A12: a12 <= AW'(acc);
              DST_A22: a22 <= AW'(acc);
              DST_DET: det <= acc;
              DST_N0:  n0  <= acc;
              DST_N1:  n1  <= acc;
              DST_N2:  n2  <= acc;
              default: ;
            endcase
            if (uidx == UOP_DET_LAST && acc == '0) begin
              // Singular system: no solve, all coefficients read as zero.
              c0    <= '0;
              c1    <= '0;
              c2    <= '0;
              fv    <= 1'b0;
              state <= ST_DONE;
            end else if (uidx == UOP_FINAL) begin
              div_idx <= 2'd0;
              state   <= ST_DIV;
            end else begin
              uidx  <= uidx + 1'b1;
              state <= ST_LOAD;
            end
          end else begin
            if (mul_b[0]) begin
              acc <= u.sub ? acc - mul_a : acc + mul_a;
            end
            mul_a <= mul_a <<< 1;
            mul_b <= mul_b >> 1;
          end
        end
        ST_DIV: begin
          state <= ST_DWAIT;
        end
        ST_DWAIT: begin
          if (div_rsp.done) begin
            unique case (div_idx)
              2'd0:    c0 <= div_rsp.coef;
              2'd1:    c1 <= div_rsp.coef;
              default: c2 <= div_rsp.coef;
            endcase
            if (div_idx == 2'd2) begin
              fv    <= 1'b1;
              state <= ST_DONE;
            end else begin
              div_idx <= div_idx + 1'b1;
              state   <= ST_DIV;
            end
          end
        end
        ST_DONE: begin
          if (!res_valid || res_ready) begin
            cnt       <= '0;
            sx        <= '0;
            sx2       <= '0;
            sx3       <= '0;
            sx4       <= '0;
            sy        <= '0;
            sxy       <= '0;
            sx2y      <= '0;
            state     <= ST_ACCUM;
          end
        end
        default: state <= ST_ACCUM;
      endcase
    end
  end

  always_ff @(posedge clk) begin
    if (state == ST_DONE && (!res_valid || res_ready)) begin
      res.coef_const  <= c0;
      res.coef_linear <= c1;
      res.coef_square <= c2;
      res.fit_valid   <= fv;
      res.points_used <= USED_W'(cnt);
    end
  end

endmodule

// File: src/qlsf_checker.sv
// ----------------------------------------------------------------------------
// qlsf_checker
// Port-level checks on the fit result channel.
// ----------------------------------------------------------------------------
module qlsf_checker (
  input logic                             clk,
  input logic                             rst,
  input logic                             out_valid,
  input logic                             out_ready,
  input logic signed [qlsf_pkg::COEF_W-1:0] coef_const,
  input logic signed [qlsf_pkg::COEF_W-1:0] coef_linear,
  input logic signed [qlsf_pkg::COEF_W-1:0] coef_square,
  input logic                             fit_valid,
  input logic [qlsf_pkg::USED_W-1:0]      points_used
);
  import qlsf_pkg::*;

  a_out_hold: assert property (@(posedge clk) disable iff (rst)
    out_valid && !out_ready |=> out_valid)
    else $error("result dropped before transfer");

  a_out_stable: assert property (@(posedge clk) disable iff (rst)
    out_valid && !out_ready |=> $stable(coef_const) && $stable(coef_linear) &&
      $stable(coef_square) && $stable(fit_valid) && $stable(points_used))
    else $error("result changed while stalled");

  a_singular_zero: assert property (@(posedge clk) disable iff (rst)
    out_valid && !fit_valid |-> coef_const == '0 && coef_linear == '0 &&
      coef_square == '0)
    else $error("singular fit carries nonzero coefficients");

  a_reset_quiet: assert property (@(posedge clk)
    rst |=> !out_valid)
    else $error("result offered right after reset");

endmodule

bind quadratic_least_squares_fit qlsf_checker u_qlsf_checker (
  .clk(clk),
  .rst(rst),
  .out_valid(fits.valid),
  .out_ready(fits.ready),
  .coef_const(fits.coef_const),
  .coef_linear(fits.coef_linear),
  .coef_square(fits.coef_square),
  .fit_valid(fits.fit_valid),
  .points_used(fits.points_used)
);

// File: tb/tb_quadratic_least_squares_fit.sv
// ----------------------------------------------------------------------------
// tb_quadratic_least_squares_fit
// Streams point sets into the quadratic fit block and checks every fit.
// Each accepted point within the point limit updates exact power sums in the bench. A point marked
// last solves the normal equations by cofactors in 256-bit arithmetic. The
// rounded, saturated Q23.24 coefficients are then queued and compared
// against the fit transfers.
// ----------------------------------------------------------------------------
module tb_quadratic_least_squares_fit;
  import qlsf_pkg::*;

  localparam int MAX_PTS = MAX_POINTS_DEF;

  typedef struct {
    logic [X_W-1:0] x;
    logic [Y_W-1:0] y;
    logic           last;
  } point_t;

  logic clk = 1'b0;
  logic rst = 1'b1;

  qlsf_point_if pt();
  qlsf_fit_if   ft();

  quadratic_least_squares_fit dut (
    .clk    (clk),
    .rst    (rst),
    .points (pt.sink),
    .fits   (ft.source)
  );

  always begin
    #2 clk = 1'b1;
    #2 clk = 1'b0;
  end

  point_t    pending_points[$];
  qlsf_fit_t expected_fits[$];
  int        mismatches = 0;
  int        items_queued = 0;

  // Exact running sums of the current point set.
  logic [63:0] n_pts, sx, sxx, sx3, sx4, sy, sxy, sxxy;

  function automatic logic signed [255:0] widen(input logic [63:0] v);
    return $signed({192'd0, v});
  endfunction

  // Round num * 2^24 / det to nearest, ties away from zero, then saturate.
  function automatic logic signed [COEF_W-1:0] q24_coef(input logic signed [255:0] num,
                                                       input logic [255:0] det);
    logic [255:0] mag, quo, lim;
    logic         neg;
    neg = num[255];
    mag = neg ? 256'(-num) : 256'(num);
    quo = ((mag << 25) + det) / (det << 1);
    lim = neg ? (256'd1 << 47) : ((256'd1 << 47) - 256'd1);
    if (quo > lim) quo = lim;
    return neg ? -quo[COEF_W-1:0] : quo[COEF_W-1:0];
  endfunction

  task automatic absorb_point(input point_t p);
    logic [63:0] x, y;
    logic signed [255:0] s0, s1, s2, s3, s4, t0, t1, t2;
    logic signed [255:0] a00, a01, a02, a11, a12, a22, det, n0, n1, n2;
    qlsf_fit_t f;
    x = 64'(p.x);
    y = 64'(p.y);
    if (n_pts < MAX_PTS) begin
      n_pts++;
      sx   += x;
      sxx  += x * x;
      sx3  += x * x * x;
      sx4  += x * x * x * x;
      sy   += y;
      sxy  += x * y;
      sxxy += x * x * y;
    end
    if (!p.last) return;
    s0 = widen(n_pts); s1 = widen(sx); s2 = widen(sxx); s3 = widen(sx3);
    s4 = widen(sx4); t0 = widen(sy); t1 = widen(sxy); t2 = widen(sxxy);
    a00 = s2 * s4 - s3 * s3;
    a01 = s2 * s3 - s1 * s4;
    a02 = s1 * s3 - s2 * s2;
    a11 = s0 * s4 - s2 * s2;
    a12 = s1 * s2 - s0 * s3;
    a22 = s0 * s2 - s1 * s1;
    det = s0 * a00 + s1 * a01 + s2 * a02;
    f.points_used = n_pts[USED_W-1:0];
    if (det == 0) begin
      f.fit_valid   = 1'b0;
      f.coef_const  = '0;
      f.coef_linear = '0;
      f.coef_square = '0;
    end else begin
      n0 = a00 * t0 + a01 * t1 + a02 * t2;
      n1 = a01 * t0 + a11 * t1 + a12 * t2;
      n2 = a02 * t0 + a12 * t1 + a22 * t2;
      if (det < 0) begin
        det = -det; n0 = -n0; n1 = -n1; n2 = -n2;
      end
      f.fit_valid   = 1'b1;
      f.coef_const  = q24_coef(n0, det);
      f.coef_linear = q24_coef(n1, det);
      f.coef_square = q24_coef(n2, det);
    end
    expected_fits = {expected_fits, f};
    n_pts = 0; sx = 0; sxx = 0; sx3 = 0; sx4 = 0; sy = 0; sxy = 0; sxxy = 0;
  endtask

  // Sender: bursts of random length separated by random gaps.
  logic pt_taken = 1'b0;
  int   burst_left = 0;
  int   gap_left = 0;

  initial begin
    pt.valid = 1'b0;
    pt.point_x = '0;
    pt.point_y = '0;
    pt.last_point = 1'b0;
    ft.ready = 1'b0;
  end

  always @(negedge clk) begin
    point_t p;
    if (rst) begin
      pt.valid <= 1'b0;
    end else if (!pt.valid || pt_taken) begin
      if (gap_left > 0) begin
        gap_left--;
        pt.valid <= 1'b0;
      end else if (pending_points.size() > 0) begin
        p = pending_points.pop_front();
        pt.point_x <= p.x;
        pt.point_y <= p.y;
        pt.last_point <= p.last;
        pt.valid <= 1'b1;
        if (burst_left > 0) begin
          burst_left--;
        end else begin
          burst_left = $urandom_range(0, 40);
          gap_left = ($urandom_range(0, 3) == 0) ? 0 : $urandom_range(1, 8);
        end
      end else begin
        pt.valid <= 1'b0;
      end
    end
  end

  // Receiver: alternating runs of readiness and stalls, some stalls empty.
  int run_left = 0;
  int stall_left = 0;

  always @(negedge clk) begin
    if (stall_left > 0) begin
      stall_left--;
      ft.ready <= 1'b0;
    end else begin
      ft.ready <= 1'b1;
      if (run_left > 0) begin
        run_left--;
      end else begin
        run_left = $urandom_range(0, 30);
        stall_left = ($urandom_range(0, 2) == 0) ? 0 : $urandom_range(1, 60);
      end
    end
  end

  always @(posedge clk) begin
    point_t    p;
    qlsf_fit_t e;
    pt_taken = pt.valid && pt.ready && !rst;
    if (pt_taken) begin
      p.x = pt.point_x;
      p.y = pt.point_y;
      p.last = pt.last_point;
      absorb_point(p);
    end
    if (!rst && ft.valid && ft.ready) begin
      if (expected_fits.size() == 0) begin
        mismatches++;
        if (mismatches <= 10)
          $display("unexpected fit transfer: const %0d lin %0d sq %0d valid %0b used %0d",
                   ft.coef_const, ft.coef_linear, ft.coef_square, ft.fit_valid,
                   ft.points_used);
      end else begin
        e = expected_fits.pop_front();
        if (ft.coef_const !== e.coef_const || ft.coef_linear !== e.coef_linear ||
            ft.coef_square !== e.coef_square || ft.fit_valid !== e.fit_valid ||
            ft.points_used !== e.points_used) begin
          mismatches++;
          if (mismatches <= 10) begin
            $display("fit mismatch: expected const %0d lin %0d sq %0d valid %0b used %0d",
                     e.coef_const, e.coef_linear, e.coef_square, e.fit_valid,
                     e.points_used);
            $display("              actual   const %0d lin %0d sq %0d valid %0b used %0d",
                     ft.coef_const, ft.coef_linear, ft.coef_square, ft.fit_valid,
                     ft.points_used);
          end
        end
      end
    end
  end

  task automatic queue_point(input int x, input int y, input bit last);
    point_t p;
    p.x = X_W'(x);
    p.y = Y_W'(y);
    p.last = last;
    pending_points = {pending_points, p};
    items_queued++;
  endtask

  // One random set. Narrow x spans give ill-conditioned, saturating fits,
  // and a single repeated x gives a singular system.
  task automatic queue_set(input int n);
    int lo, hi, shape, cx, a, b, c, y;
    shape = $urandom_range(0, 9);
    lo = $urandom_range(0, 1023);
    hi = (shape < 2) ? lo : ((shape < 4) ? lo + $urandom_range(1, 8) : 1023);
    if (hi > 1023) hi = 1023;
    if (shape >= 4) lo = $urandom_range(0, 300);
    a = $urandom_range(0, 511);
    b = $urandom_range(0, 200);
    c = $urandom_range(0, 20);
    for (int i = 0; i < n; i++) begin
      cx = $urandom_range(lo, hi);
      if (shape >= 7) y = $urandom_range(0, 511);
      else y = (a + ((cx - lo) * b) / 256 + ((cx - lo) * (cx - lo) * c) / 65536
                + $urandom_range(0, 6)) % 512;
      queue_point(cx, y, i == n - 1);
    end
  endtask

  initial begin
    n_pts = 0; sx = 0; sxx = 0; sx3 = 0; sx4 = 0; sy = 0; sxy = 0; sxxy = 0;
    // An isolated last point is a singular one-point set.
    queue_point(0, 0, 1);
    // Two distinct x values are still singular.
    queue_point(1023, 511, 0);
    queue_point(0, 0, 1);
    // Three points at the same x.
    queue_point(512, 10, 0);
    queue_point(512, 300, 0);
    queue_point(512, 511, 1);
    // Extremes of both coordinates, a well-posed fit.
    queue_point(0, 511, 0);
    queue_point(1023, 0, 0);
    queue_point(512, 511, 0);
    queue_point(1023, 511, 1);
    // Closely spaced x at the top of the range drive the constant coefficient to saturation.
    queue_point(1021, 0, 0);
    queue_point(1022, 511, 0);
    queue_point(1023, 0, 1);
    queue_point(1021, 511, 0);
    queue_point(1022, 0, 0);
    queue_point(1023, 511, 1);
    // A straight line and a flat line.
    queue_point(0, 1, 0);
    queue_point(100, 101, 0);
    queue_point(200, 201, 0);
    queue_point(300, 301, 1);
    queue_point(640, 480, 0);
    queue_point(641, 480, 0);
    queue_point(700, 480, 1);
    // A full set past the point limit; the extra points are dropped.
    for (int i = 0; i < MAX_PTS + 6; i++)
      queue_point($urandom_range(0, 1023), $urandom_range(0, 511), i == MAX_PTS + 5);
    while (items_queued < 1300) begin
      if ($urandom_range(0, 19) == 0) queue_set($urandom_range(30, 150));
      else queue_set($urandom_range(1, 16));
    end
    repeat (6) @(posedge clk);
    @(negedge clk);
    rst <= 1'b0;
    while (pending_points.size() != 0 || pt.valid || expected_fits.size() != 0)
      @(posedge clk);
    repeat (2500) @(posedge clk);
    if (mismatches == 0 && expected_fits.size() == 0) begin
      $display("TEST PASSED");
    end else begin
      $display("TEST FAILED");
    end
    $finish;
  end

  initial begin
    #40000000;
    $display("TEST FAILED");
    $finish;
  end

endmodule
